// ----- rtl/height_to_normal_map_assert.svh -----
// Assertion macros shared by the checker of the height to normal map block.
// Needs a clk and an rst signal in the scope where the macros are used.
`ifndef HEIGHT_TO_NORMAL_MAP_ASSERT_SVH
`define HEIGHT_TO_NORMAL_MAP_ASSERT_SVH

// same-cycle implication, ignored during reset
`define HTN_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("height_to_normal_map assertion failed");

// next-cycle implication, ignored during reset
`define HTN_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("height_to_normal_map assertion failed");

// next-cycle implication that also holds across reset
`define HTN_ASSERT_ALWAYS_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("height_to_normal_map assertion failed");

`endif

// ----- rtl/htn_pkg.sv -----
// Types and constants of the height to normal map block.
// No dependencies.
package htn_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_ZTERM  = 2'd2;

  // normal components
  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  // sequencing lengths
  localparam logic [4:0] FETCH_LAST = 5'd5;
  localparam logic [4:0] SQRT_LAST  = 5'd24;
  localparam logic [4:0] DIV_LAST   = 5'd16;

  // reset values of the registers
  localparam logic [10:0] RST_WIDTH  = 11'd1024;
  localparam logic [12:0] RST_HEIGHT = 13'd1024;
  localparam logic [15:0] RST_ZTERM  = 16'd6528;

  // 1.0 in Q16
  localparam logic [16:0] Q_ONE = 17'd65536;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SELECT,
    ST_FETCH,
    ST_SQUARE,
    ST_SUM,
    ST_SQRT,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_END,
    ST_OUT
  } htn_state_t;

  // controller to datapath
  typedef struct packed {
    logic       load;
    logic       start;
    logic [1:0] idx;
    logic       fetch;
    logic [2:0] step;
    logic       square;
    logic       sum;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       div_end;
    logic [1:0] comp;
    logic       out_load;
    logic       last;
  } htn_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [3:0] flags;
    logic       out_free;
  } htn_stat_t;

endpackage

// ----- rtl/htn_if.sv -----
// Channel interfaces of the height to normal map block: heights in,
// normals out, configuration writes. No dependencies.
interface htn_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] height;
  modport source (output valid, output height, input ready);
  modport sink (input valid, input height, output ready);
endinterface

interface htn_nrm_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [9:0]  pos_x;
  logic [11:0] pos_y;
  logic        last;
  modport source (output valid, output red, output green, output blue, output alpha,
                  output pos_x, output pos_y, output last, input ready);
  modport sink (input valid, input red, input green, input blue, input alpha,
                input pos_x, input pos_y, input last, output ready);
endinterface

interface htn_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ----- rtl/htn_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module htn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 3072
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/htn_ctrl.sv -----
// Sequencer of the height to normal map block: walks each accepted height
// through its results. Depends on htn_pkg.
module htn_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  htn_pkg::htn_stat_t stat,
  output htn_pkg::htn_cmd_t  cmd
);
  import htn_pkg::*;

  htn_state_t state, state_next;
  logic [4:0] cnt, cnt_next;
  logic [1:0] comp, comp_next;
  logic [3:0] mask, mask_next;
  logic       last, last_next;
  logic [1:0] low_idx;
  logic [3:0] low_bit;

  // lowest pending result
  always_comb begin
    low_idx = 2'd3;
    low_bit = 4'b1000;
    if (mask[0]) begin
      low_idx = 2'd0;
      low_bit = 4'b0001;
    end else if (mask[1]) begin
      low_idx = 2'd1;
      low_bit = 4'b0010;
    end else if (mask[2]) begin
      low_idx = 2'd2;
      low_bit = 4'b0100;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    comp_next  = comp;
    mask_next  = mask;
    last_next  = last;
    case (state)
      ST_IDLE: begin
        if (in_valid) state_next = ST_LOAD;
      end
      ST_LOAD: begin
        mask_next  = stat.flags;
        state_next = ST_SELECT;
      end
      ST_SELECT: begin
        if (mask == 4'd0) begin
          state_next = ST_IDLE;
        end else begin
          mask_next  = mask & ~low_bit;
          last_next  = (mask & ~low_bit) == 4'd0;
          cnt_next   = 5'd0;
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        cnt_next = cnt + 5'd1;
        if (cnt == FETCH_LAST) state_next = ST_SQUARE;
      end
      ST_SQUARE: state_next = ST_SUM;
      ST_SUM: begin
        cnt_next   = 5'd0;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cnt_next = cnt + 5'd1;
        if (cnt == SQRT_LAST) begin
          comp_next  = COMP_X;
          state_next = ST_DIV_INIT;
        end
      end
      ST_DIV_INIT: begin
        cnt_next   = 5'd0;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cnt_next = cnt + 5'd1;
        if (cnt == DIV_LAST) state_next = ST_DIV_END;
      end
      ST_DIV_END: begin
        if (comp == COMP_Z) begin
          state_next = ST_OUT;
        end else begin
          comp_next  = comp + 2'd1;
          state_next = ST_DIV_INIT;
        end
      end
      ST_OUT: begin
        if (stat.out_free) state_next = ST_SELECT;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd           = '0;
    cmd.idx       = low_idx;
    cmd.step      = cnt[2:0];
    cmd.comp      = comp;
    cmd.last      = last;
    in_ready      = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SELECT:   cmd.start     = mask != 4'd0;
      ST_FETCH:    cmd.fetch     = 1'b1;
      ST_SQUARE:   cmd.square    = 1'b1;
      ST_SUM:      cmd.sum       = 1'b1;
      ST_SQRT:     cmd.sqrt_step = 1'b1;
      ST_DIV_INIT: cmd.div_init  = 1'b1;
      ST_DIV:      cmd.div_step  = 1'b1;
      ST_DIV_END:  cmd.div_end   = 1'b1;
      ST_OUT:      cmd.out_load  = stat.out_free;
      default:     cmd.load      = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= 5'd0;
      comp  <= COMP_X;
      mask  <= 4'd0;
      last  <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      comp  <= comp_next;
      mask  <= mask_next;
      last  <= last_next;
    end
  end
endmodule

// ----- rtl/htn_dp.sv -----
// Datapath of the height to normal map block: registers, position counters,
// line store, square root and divider. Depends on htn_pkg and htn_ram.
module htn_dp #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic               clk,
  input  logic               rst,
  input  htn_pkg::htn_cmd_t  cmd,
  output htn_pkg::htn_stat_t stat,
  input  logic [7:0]         height,
  input  logic               cfg_valid,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  input  logic               out_ready,
  output logic               out_valid,
  output logic [7:0]         red,
  output logic [7:0]         green,
  output logic [7:0]         blue,
  output logic [7:0]         alpha,
  output logic [9:0]         pos_x,
  output logic [11:0]        pos_y,
  output logic               last
);
  import htn_pkg::*;

  localparam int AW = $clog2(3 * MAX_WIDTH);

  function automatic logic [AW-1:0] ram_addr(logic [1:0] s, logic [10:0] x);
    logic [AW-1:0] b;
    case (s)
      2'd0:    b = '0;
      2'd1:    b = AW'(MAX_WIDTH);
      default: b = AW'(2 * MAX_WIDTH);
    endcase
    return b + AW'(x);
  endfunction

  // configuration
  logic [10:0] image_width;
  logic [12:0] image_height;
  logic [15:0] z_term;
  logic [10:0] w_eff;
  logic [12:0] h_eff;
  logic [15:0] z_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= RST_WIDTH;
      image_height <= RST_HEIGHT;
      z_term       <= RST_ZTERM;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data[10:0];
        REG_HEIGHT: image_height <= cfg_data[12:0];
        REG_ZTERM:  z_term       <= cfg_data;
        default:    z_term       <= z_term;
      endcase
    end
  end

  always_comb begin
    w_eff = image_width;
    if (image_width == 11'd0) w_eff = 11'd1;
    else if (32'(image_width) > MAX_WIDTH) w_eff = 11'(MAX_WIDTH);
    h_eff = image_height;
    if (image_height == 13'd0) h_eff = 13'd1;
    else if (32'(image_height) > MAX_HEIGHT) h_eff = 13'(MAX_HEIGHT);
    z_eff = (z_term == 16'd0) ? 16'd1 : z_term;
  end

  // raster position of the next input, slot = row mod 3
  logic [10:0] col_count;
  logic [12:0] row_count;
  logic [1:0]  slot;
  logic        geo_write;
  logic        row_end;
  logic [3:0]  flags_now;

  assign geo_write = cfg_valid && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);
  assign row_end   = col_count == w_eff - 11'd1;

  always_ff @(posedge clk) begin
    if (rst || geo_write) begin
      col_count <= 11'd0;
      row_count <= 13'd0;
      slot      <= 2'd0;
    end else if (cmd.load) begin
      if (row_end) begin
        col_count <= 11'd0;
        if (row_count + 13'd1 >= h_eff) begin
          row_count <= 13'd0;
          slot      <= 2'd0;
        end else begin
          row_count <= row_count + 13'd1;
          slot      <= (slot == 2'd2) ? 2'd0 : slot + 2'd1;
        end
      end else begin
        col_count <= col_count + 11'd1;
      end
    end
  end

  // which results this input releases
  always_comb begin
    flags_now[0] = row_count != 13'd0 && col_count != 11'd0;
    flags_now[1] = row_count != 13'd0 && row_end;
    flags_now[2] = row_count == h_eff - 13'd1 && col_count != 11'd0;
    flags_now[3] = row_count == h_eff - 13'd1 && row_end;
  end

  // captured input position
  logic [3:0]  flags;
  logic [10:0] item_c;
  logic [12:0] item_r;
  logic [1:0]  item_slot;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      flags     <= flags_now;
      item_c    <= col_count;
      item_r    <= row_count;
      item_slot <= slot;
    end
  end

  // neighbor positions of the pixel being emitted
  logic [10:0] ex, ex_n, xl, xr;
  logic [12:0] ey, ey_n;
  logic [1:0]  s_up, s_mid, s_dn;
  logic [1:0]  prev, prev2;
  logic        y_cur;

  assign prev  = (item_slot == 2'd0) ? 2'd2 : item_slot - 2'd1;
  assign prev2 = (item_slot == 2'd2) ? 2'd0 : item_slot + 2'd1;
  assign y_cur = cmd.idx[1];
  assign ex_n  = cmd.idx[0] ? item_c : item_c - 11'd1;
  assign ey_n  = y_cur ? item_r : item_r - 13'd1;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ex    <= ex_n;
      ey    <= ey_n;
      xl    <= (ex_n == 11'd0) ? 11'd0 : ex_n - 11'd1;
      xr    <= ({1'b0, ex_n} + 12'd1 < {1'b0, w_eff}) ? ex_n + 11'd1 : w_eff - 11'd1;
      s_mid <= y_cur ? item_slot : prev;
      s_dn  <= item_slot;
      if (y_cur) s_up <= (item_r == 13'd0) ? item_slot : prev;
      else       s_up <= (ey_n == 13'd0) ? prev : prev2;
    end
  end

  // line store
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;

  always_comb begin
    case (cmd.step)
      3'd0:    raddr = ram_addr(s_mid, ex);
      3'd1:    raddr = ram_addr(s_mid, xl);
      3'd2:    raddr = ram_addr(s_mid, xr);
      3'd3:    raddr = ram_addr(s_up, ex);
      default: raddr = ram_addr(s_dn, ex);
    endcase
  end

  htn_ram #(.WIDTH(8), .DEPTH(3 * MAX_WIDTH)) u_ram (
    .clk   (clk),
    .we    (cmd.load),
    .waddr (ram_addr(slot, col_count)),
    .wdata (height),
    .raddr (raddr),
    .rdata (rdata)
  );

  // neighbor heights, one read per cycle
  logic [7:0] h_c, h_l, h_r, h_u, h_d;

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      case (cmd.step)
        3'd1:    h_c <= rdata;
        3'd2:    h_l <= rdata;
        3'd3:    h_r <= rdata;
        3'd4:    h_u <= rdata;
        3'd5:    h_d <= rdata;
        default: h_c <= h_c;
      endcase
    end
  end

  // differences and squares
  logic [8:0]  dx, dy;
  logic [7:0]  adx, ady;
  logic        neg_x, neg_y;
  logic [15:0] sqx, sqy;
  logic [31:0] sqz;

  assign dx = {1'b0, h_l} - {1'b0, h_r};
  assign dy = {1'b0, h_u} - {1'b0, h_d};

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      neg_x <= dx[8];
      neg_y <= dy[8];
      adx   <= dx[8] ? 8'(-dx) : dx[7:0];
      ady   <= dy[8] ? 8'(-dy) : dy[7:0];
      sqx   <= (dx[8] ? 8'(-dx) : dx[7:0]) * (dx[8] ? 8'(-dx) : dx[7:0]);
      sqy   <= (dy[8] ? 8'(-dy) : dy[7:0]) * (dy[8] ? 8'(-dy) : dy[7:0]);
      sqz   <= z_eff * z_eff;
    end
  end

  // vector length, two radicand bits per cycle
  logic [49:0] rad;
  logic [26:0] rem;
  logic [24:0] root;
  logic [33:0] sum;
  logic [28:0] rem_w;
  logic [28:0] trial;

  assign sum   = {2'b0, sqx, 16'd0} + {2'b0, sqy, 16'd0} + {2'b0, sqz};
  assign rem_w = {rem, rad[49:48]};
  assign trial = {2'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.sum) begin
      rad  <= {sum, 16'd0};
      rem  <= 27'd0;
      root <= 25'd0;
    end else if (cmd.sqrt_step) begin
      rad <= {rad[47:0], 2'b00};
      if (rem_w >= trial) begin
        rem  <= 27'(rem_w - trial);
        root <= {root[23:0], 1'b1};
      end else begin
        rem  <= rem_w[26:0];
        root <= {root[23:0], 1'b0};
      end
    end
  end

  // component / length, one quotient bit per cycle
  logic [25:0] drem;
  logic [16:0] quo;
  logic        neg;
  logic [15:0] mag;
  logic [26:0] drem_w;

  always_comb begin
    case (cmd.comp)
      COMP_X:  mag = {adx, 8'd0};
      COMP_Y:  mag = {ady, 8'd0};
      default: mag = z_eff;
    endcase
  end

  assign drem_w = {drem, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      drem <= {3'd0, mag, 7'd0};
      quo  <= 17'd0;
      case (cmd.comp)
        COMP_X:  neg <= neg_x && adx != 8'd0;
        COMP_Y:  neg <= neg_y && ady != 8'd0;
        default: neg <= 1'b0;
      endcase
    end else if (cmd.div_step) begin
      if (drem_w >= {2'b0, root}) begin
        drem <= 26'(drem_w - {2'b0, root});
        quo  <= {quo[15:0], 1'b1};
      end else begin
        drem <= drem_w[25:0];
        quo  <= {quo[15:0], 1'b0};
      end
    end
  end

  // map Q16 component to a byte
  logic [16:0] q_sat;
  logic [17:0] biased;
  logic [25:0] scaled;
  logic [7:0]  byte_val;

  always_comb begin
    q_sat    = (quo > Q_ONE) ? Q_ONE : quo;
    biased   = neg ? {1'b0, Q_ONE} - {1'b0, q_sat} : {1'b0, Q_ONE} + {1'b0, q_sat};
    scaled   = {biased, 8'd0} - {8'd0, biased};
    byte_val = (scaled[25:17] > 9'd255) ? 8'd255 : scaled[24:17];
  end

  logic [7:0] b_x, b_y, b_z;

  always_ff @(posedge clk) begin
    if (cmd.div_end) begin
      case (cmd.comp)
        COMP_X:  b_x <= byte_val;
        COMP_Y:  b_y <= byte_val;
        default: b_z <= byte_val;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      red   <= b_x;
      green <= b_y;
      blue  <= b_z;
      alpha <= h_c;
      pos_x <= ex[9:0];
      pos_y <= ey[11:0];
      last  <= cmd.last;
    end
  end

  assign stat.flags    = flags;
  assign stat.out_free = !out_valid || out_ready;
endmodule

// ----- rtl/height_to_normal_map.sv -----
// Height to normal map, top level: sequencer, datapath and channel wiring.
// Depends on htn_pkg, htn_if, htn_ctrl and htn_dp.
//
// Heights enter on pix in raster order, one request per pixel. Each request
// releases zero to four normals on nrm, each tagged with its column and row;
// last marks the final normal of a request. A pixel comes out once its right
// and lower neighbors have arrived, so a row lags one row behind the input.
// cfg writes image_width (0), image_height (1) and z_term (2); it is always
// ready. Writing either geometry register restarts the frame.
// The block works on one request at a time. Each normal reads the five
// neighbors through the single read port, then takes 25 square-root steps
// at two bits per cycle and three 17-bit quotient divisions, plus sequencing.
// A normal waits in the output register while nrm.ready is low; the
// sequencer holds until it is taken. Synchronous reset clears the counters,
// the registers to their defaults and the output valid; the line store is not
// cleared and needs no pass, since only pixels of the current frame are read.
module height_to_normal_map #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input logic      clk,
  input logic      rst,
  htn_pix_if.sink  pix,
  htn_cfg_if.sink  cfg,
  htn_nrm_if.source nrm
);
  import htn_pkg::*;

  htn_cmd_t  cmd;
  htn_stat_t stat;

  assign cfg.ready = 1'b1;

  htn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (pix.valid),
    .in_ready (pix.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  htn_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .height    (pix.height),
    .cfg_valid (cfg.valid),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .out_ready (nrm.ready),
    .out_valid (nrm.valid),
    .red       (nrm.red),
    .green     (nrm.green),
    .blue      (nrm.blue),
    .alpha     (nrm.alpha),
    .pos_x     (nrm.pos_x),
    .pos_y     (nrm.pos_y),
    .last      (nrm.last)
  );
endmodule

// ----- rtl/htn_checker.sv -----
// Port-level checks of the height to normal map block, bound to the top.
// Depends on height_to_normal_map_assert.svh.
`include "height_to_normal_map_assert.svh"

module htn_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  blue,
  input logic [9:0]  pos_x,
  input logic [11:0] pos_y,
  input logic        last
);
  // a stalled normal keeps its request
  `HTN_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(blue) && $stable(pos_x) && $stable(pos_y) && $stable(last))

  // z is always positive, so blue never maps below the midpoint
  `HTN_ASSERT_IMP(a_blue_half, out_valid, blue >= 8'd127)

  // an accepted height keeps the block busy for the next cycle
  `HTN_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // reset leaves no normal pending
  `HTN_ASSERT_ALWAYS_NEXT(a_reset_empty, rst, !out_valid)
endmodule

bind height_to_normal_map htn_checker u_htn_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (pix.valid),
  .in_ready  (pix.ready),
  .out_valid (nrm.valid),
  .out_ready (nrm.ready),
  .blue      (nrm.blue),
  .pos_x     (nrm.pos_x),
  .pos_y     (nrm.pos_y),
  .last      (nrm.last)
);

// ----- tb/tb_height_to_normal_map.sv -----
// Testbench of the height to normal map block: directed and random height
// streams checked against a scoreboard that predicts every normal.
// Depends on htn_pkg, htn_if and height_to_normal_map.
`timescale 1ns / 100ps

module tb_height_to_normal_map;
  import htn_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int         LINE = 1024;

  typedef struct {
    bit [7:0]  red;
    bit [7:0]  green;
    bit [7:0]  blue;
    bit [7:0]  alpha;
    bit [9:0]  pos_x;
    bit [11:0] pos_y;
    bit        last;
  } normal_t;

  // predicts normals from the height stream and checks what comes out
  class normal_scoreboard;
    bit [7:0]  line_store [0:3*LINE-1];
    int        col, row;
    bit [10:0] width_reg;
    bit [12:0] height_reg;
    bit [15:0] zterm_reg;
    normal_t   pending_normals[$];
    int        errors, heights_seen, normals_seen;

    function new();
      col = 0; row = 0;
      width_reg = RST_WIDTH; height_reg = RST_HEIGHT; zterm_reg = RST_ZTERM;
      errors = 0; heights_seen = 0; normals_seen = 0;
    endfunction

    function void write_reg(bit [1:0] idx, bit [15:0] data);
      case (idx)
        REG_WIDTH: begin
          width_reg = data[10:0]; col = 0; row = 0;
        end
        REG_HEIGHT: begin
          height_reg = data[12:0]; col = 0; row = 0;
        end
        REG_ZTERM: zterm_reg = data;
        default: ;
      endcase
    endfunction

    function int pix(int x, int y);
      return line_store[(y % 3) * LINE + x];
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    // signed Q8 component over the Q16 length, mapped to a byte
    function bit [7:0] comp_byte(longint c, longint len8);
      longint mag, q, b;
      mag = (c < 0) ? -c : c;
      q = (mag << 24) / len8;
      if (q > 65536) q = 65536;
      if (c < 0) q = -q;
      b = ((q + 65536) * 255) >>> 17;
      if (b > 255) b = 255;
      return b[7:0];
    endfunction

    function void predict_normal(int x, int y, int w, int h);
      normal_t n;
      int xl, xr, yu, yd;
      longint cx, cy, cz, len8;
      longint unsigned sum;
      xl = x ? x - 1 : 0;
      xr = (x + 1 < w) ? x + 1 : w - 1;
      yu = y ? y - 1 : 0;
      yd = (y + 1 < h) ? y + 1 : h - 1;
      cx = (pix(xl, y) - pix(xr, y)) * 256;
      cy = (pix(x, yu) - pix(x, yd)) * 256;
      cz = (zterm_reg == 0) ? 1 : zterm_reg;
      sum = cx * cx + cy * cy + cz * cz;
      len8 = int_sqrt(sum << 16);
      if (len8 == 0) len8 = 1;
      n.red = comp_byte(cx, len8);
      n.green = comp_byte(cy, len8);
      n.blue = comp_byte(cz, len8);
      n.alpha = 8'(pix(x, y));
      n.pos_x = 10'(x);
      n.pos_y = 12'(y);
      n.last = 0;
      pending_normals = {pending_normals, n};
    endfunction

    // one accepted height request
    function void note_height(bit [7:0] hgt);
      int w, h, count_prior;
      w = (width_reg < 1) ? 1 : (width_reg > LINE) ? LINE : width_reg;
      h = (height_reg < 1) ? 1 : (height_reg > 4096) ? 4096 : height_reg;
      if (col >= w) col = 0;
      if (row >= h) row = 0;
      count_prior = pending_normals.size();
      heights_seen++;
      line_store[(row % 3) * LINE + col] = hgt;
      if (row >= 1) begin
        if (col >= 1) predict_normal(col - 1, row - 1, w, h);
        if (col == w - 1) predict_normal(col, row - 1, w, h);
      end
      if (row == h - 1) begin
        if (col >= 1) predict_normal(col - 1, row, w, h);
        if (col == w - 1) predict_normal(col, row, w, h);
      end
      if (pending_normals.size() > count_prior)
        pending_normals[pending_normals.size() - 1].last = 1;
      col++;
      if (col >= w) begin
        col = 0;
        row++;
        if (row >= h) row = 0;
      end
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_normal(normal_t got);
      normal_t e;
      normals_seen++;
      if (pending_normals.size() == 0) begin
        report($sformatf("unexpected normal at x=%0d y=%0d", got.pos_x, got.pos_y));
        return;
      end
      e = pending_normals.pop_front();
      if (got.red != e.red) report($sformatf("red %0d, want %0d", got.red, e.red));
      if (got.green != e.green) report($sformatf("green %0d, want %0d", got.green, e.green));
      if (got.blue != e.blue) report($sformatf("blue %0d, want %0d", got.blue, e.blue));
      if (got.alpha != e.alpha) report($sformatf("alpha %0d, want %0d", got.alpha, e.alpha));
      if (got.pos_x != e.pos_x) report($sformatf("pos_x %0d, want %0d", got.pos_x, e.pos_x));
      if (got.pos_y != e.pos_y) report($sformatf("pos_y %0d, want %0d", got.pos_y, e.pos_y));
      if (got.last != e.last) report($sformatf("last %0d, want %0d", got.last, e.last));
    endtask
  endclass

  logic clk, rst;
  htn_pix_if pix ();
  htn_cfg_if cfg ();
  htn_nrm_if nrm ();

  height_to_normal_map dut (
    .clk (clk),
    .rst (rst),
    .pix (pix),
    .cfg (cfg),
    .nrm (nrm)
  );

  normal_scoreboard normals;
  bit no_gaps;     // stretch with both sides at full rate
  bit hold_off;    // asks the receiver for one long stall
  int phases;

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("FAIL");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    normal_t got;
    int gap;
    nrm.ready = 1'b0;
    @(posedge clk iff !rst);
    forever begin
      gap = no_gaps ? 0 : $urandom_range(0, 15);
      nrm.ready <= (gap == 0 && !hold_off);
      if (hold_off) begin
        repeat (400) @(posedge clk);
        hold_off = 0;
      end
      repeat (gap) @(posedge clk);
      nrm.ready <= 1'b1;
      do @(posedge clk); while (!(nrm.valid && nrm.ready));
      got.red = nrm.red; got.green = nrm.green; got.blue = nrm.blue;
      got.alpha = nrm.alpha; got.pos_x = nrm.pos_x; got.pos_y = nrm.pos_y;
      got.last = nrm.last;
      normals.check_normal(got);
    end
  end

  task automatic send_height(bit [7:0] hgt);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      pix.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    pix.valid <= 1'b1;
    pix.height <= hgt;
    do @(posedge clk); while (!(pix.valid && pix.ready));
    normals.note_height(hgt);
  endtask

  // stop offering and wait until every predicted normal is out
  task automatic drain();
    pix.valid <= 1'b0;
    while (normals.pending_normals.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(bit [1:0] idx, bit [15:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    do @(posedge clk); while (!(cfg.valid && cfg.ready));
    normals.write_reg(idx, data);
    cfg.valid <= 1'b0;
  endtask

  task automatic set_image(int w, int h, int z);
    drain();
    write_reg(REG_WIDTH, 16'(w));
    write_reg(REG_HEIGHT, 16'(h));
    write_reg(REG_ZTERM, 16'(z));
    phases++;
  endtask

  initial begin
    int w, h, n;
    normals = new();
    phases = 0;
    no_gaps = 0;
    hold_off = 0;
    pix.valid = 1'b0; pix.height = '0;
    cfg.valid = 1'b0; cfg.index = '0; cfg.data = '0;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // at reset geometry the first row releases nothing
    send_height(8'd255);
    send_height(8'd0);
    // zero geometry counts as a one-pixel image
    set_image(0, 0, 1);
    send_height(8'd255);
    send_height(8'd0);
    // 3x3 with zero z_term, steepest slopes
    set_image(3, 3, 0);
    send_height(8'd255); send_height(8'd0); send_height(8'd255);
    send_height(8'd0); send_height(8'd255); send_height(8'd0);
    send_height(8'd255); send_height(8'd0); send_height(8'd255);
    // oversized geometry clamps, maximum z_term
    set_image(2047, 8191, 65535);
    repeat (3) send_height(8'($urandom_range(0, 255)));
    // the start of a single row at the widest width, unknown register ignored
    set_image(2047, 1, 65535);
    write_reg(REG_UNUSED, 16'd5);
    repeat (6) send_height(8'($urandom_range(0, 255)));

    // random phases of whole frames, now and then a broken one
    while (normals.heights_seen < 265) begin
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2047) : $urandom_range(1, 6);
      h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 8191) : $urandom_range(1, 5);
      set_image(w, h, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(1, 2048));
      no_gaps = ($urandom_range(0, 3) == 0);
      if (phases == 8) hold_off = 1;
      w = (w < 1) ? 1 : (w > LINE) ? LINE : w;
      h = (h < 1) ? 1 : (h > 4096) ? 4096 : h;
      n = (w * h <= 40) ? w * h * $urandom_range(1, 2) : $urandom_range(5, 30);
      if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
      for (int i = 0; i < n; i++) begin
        // smooth slopes mostly, full-range noise sometimes
        if ($urandom_range(0, 2) == 0) send_height(8'($urandom_range(0, 255)));
        else send_height(8'(128 + $urandom_range(0, 15) - 8));
        if (phases == 12 && i == n / 2) drain();
      end
    end
    no_gaps = 0;
    drain();

    $display("run covered %0d heights in %0d image setups, %0d normals checked",
             normals.heights_seen, phases, normals.normals_seen);
    if (normals.errors == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", normals.errors);
      $display("FAIL");
    end
    $finish;
  end

endmodule
